FILE: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key-value cache
// Holds the command codes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none
package lkv_pkg;
  localparam int KeyW = 32;
  localparam int ValW = 32;
  localparam int CapW = 7;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and run the match
    logic commit;  // apply rank/valid/store updates, form the result
  } dp_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/lkv_if.sv
// ----------------------------------------------------------------------------
// lkv_req_if / lkv_rsp_if: valid-ready channels of the cache
// One interface per channel, each with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none
interface lkv_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] key;
  logic [31:0] value;
  modport source (output valid, command, key, value, input ready);
  modport sink   (input valid, command, key, value, output ready);
endinterface

interface lkv_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] data_out;
  modport source (output valid, found, data_out, input ready);
  modport sink   (input valid, found, data_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative LRU key-value cache
// Top level joining the request sequencer and the entry datapath.
// ----------------------------------------------------------------------------
// Usage: each request on the in_ channel is a get (command 0) or a put
// (command 1) with a 32-bit key and value. Every request yields exactly one
// result on the out_ channel: found and data_out.
// The key is compared against all entries in parallel in the cycle it is
// accepted, and the match and the least recent entry are registered; the
// next cycle updates the recency ranks and the stores and registers the
// result. A new request is taken only after that rank update, which the
// next match depends on.
// The result is held in an output register; a new request is taken in the
// same cycle the held result is taken. While the receiver stalls, the
// result holds and no request is accepted.
// Reset clears all entry valid bits, the entry count and sets the capacity
// to 64. No clearing pass is needed. The user must write the capacity through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_key_value_cache_unit #(
  parameter int ENTRIES = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lkv_req_if.sink     in_req,
  lkv_rsp_if.source   out_rsp,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata
);
  logic [6:0] capacity_r;
  lkv_pkg::dp_cmd_t cmd;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) capacity_r <= 7'd64;
    else if (cfg_we) capacity_r <= cfg_wdata;
  end

  lkv_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .req_valid(in_req.valid), .req_ready(in_req.ready),
    .rsp_valid(out_rsp.valid), .rsp_ready(out_rsp.ready),
    .cmd(cmd)
  );

  lkv_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_command(in_req.command), .in_key(in_req.key), .in_value(in_req.value),
    .capacity(capacity_r),
    .found(out_rsp.found), .data_out(out_rsp.data_out)
  );
endmodule
`default_nettype wire

FILE: rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl: request sequencer
// Two-step sequence per request: match, then update and present the result.
// ----------------------------------------------------------------------------
`default_nettype none
module lkv_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output lkv_pkg::dp_cmd_t    cmd
);
  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_HOLD} state_t;
  state_t state_r;

  // A request is taken when idle, or when the held result leaves this cycle.
  assign rsp_valid = (state_r == S_HOLD);
  assign req_ready = (state_r == S_IDLE) || (rsp_valid && rsp_ready);
  assign cmd.load   = req_valid && req_ready;
  assign cmd.commit = (state_r == S_MATCH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE:  if (req_valid) state_r <= S_MATCH;
        S_MATCH: state_r <= S_HOLD;
        S_HOLD: begin
          if (rsp_ready) state_r <= req_valid ? S_MATCH : S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_commit_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.commit) else $error("commit did not follow load");
  a_hold_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> rsp_valid) else $error("result not presented");
  a_no_load_in_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !cmd.load) else $error("load during match");
endmodule
`default_nettype wire

FILE: rtl/lkv_dp.sv
// ----------------------------------------------------------------------------
// lkv_dp: entry storage, parallel key match and recency ranks
// The load step registers the match vector; the commit step then updates ranks and stores.
// ----------------------------------------------------------------------------
`default_nettype none
module lkv_dp #(
  parameter int ENTRIES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lkv_pkg::dp_cmd_t cmd,
  input  wire logic             in_command,
  input  wire logic [31:0]      in_key,
  input  wire logic [31:0]      in_value,
  input  wire logic [6:0]       capacity,
  output logic                  found,
  output logic [31:0]           data_out
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [31:0]  key_r   [ENTRIES];
  logic [31:0]  val_r   [ENTRIES];
  logic [IW-1:0] rank_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [CW-1:0] count_r;

  logic          cmd_r;
  logic [31:0]   rkey_r, rval_r;
  logic [ENTRIES-1:0] hit_r;
  logic [ENTRIES-1:0] old_r;   // valid entry with the largest rank
  logic          found_r;
  logic [31:0]   data_r;

  // Match and oldest detection from the current state.
  logic [ENTRIES-1:0] hit_c, old_c;
  logic [CW-1:0] cmax_c;
  always_comb begin
    cmax_c = (count_r == '0) ? CW'(0) : CW'(count_r - 1'b1);
    for (int i = 0; i < ENTRIES; i++) begin
      hit_c[i] = valid_r[i] && (key_r[i] == in_key);
      old_c[i] = valid_r[i] && (CW'(rank_r[i]) == cmax_c);
    end
  end

  // Effective capacity and free slot (lowest invalid).
  logic [CW:0] cap_c;
  logic [IW-1:0] free_c;
  logic [IW-1:0] hidx_c, oidx_c;
  always_comb begin
    if (capacity == 7'd0) cap_c = (CW+1)'(1);
    else if (32'(capacity) > ENTRIES) cap_c = (CW+1)'(ENTRIES);
    else cap_c = (CW+1)'(capacity);
    free_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) if (!valid_r[i]) free_c = IW'(i);
    hidx_c = '0;
    oidx_c = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_r[i]) hidx_c = IW'(i);
      if (old_r[i]) oidx_c = IW'(i);
    end
  end

  logic hit_any, use_free, any_valid;
  logic [IW-1:0] slot_c, tref_c;
  assign hit_any   = |hit_r;
  assign any_valid = |valid_r;
  assign use_free  = ({1'b0, count_r} < cap_c) && !(&valid_r);
  assign slot_c    = hit_any ? hidx_c : (use_free ? free_c : (any_valid ? oidx_c : '0));
  assign tref_c    = rank_r[slot_c];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      rkey_r <= in_key;
      rval_r <= in_value;
      hit_r  <= hit_c;
      old_r  <= old_c;
    end
    if (cmd.commit) begin
      found_r <= hit_any && (cmd_r == lkv_pkg::CMD_GET || cmd_r == lkv_pkg::CMD_PUT);
      if (cmd_r == lkv_pkg::CMD_GET) begin
        data_r <= hit_any ? val_r[hidx_c] : 32'hFFFF_FFFF;
      end else begin
        data_r <= '0;
      end
    end
  end

  // Rank, store and valid updates.
  logic touch_c, add_c;
  assign touch_c = cmd.commit && (hit_any || (cmd_r == lkv_pkg::CMD_PUT && !use_free &&
                   any_valid)) && (cmd_r == lkv_pkg::CMD_PUT || hit_any);
  assign add_c   = cmd.commit && cmd_r == lkv_pkg::CMD_PUT && !hit_any &&
                   (use_free || !any_valid);

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (touch_c) begin
        if (IW'(i) == slot_c) rank_r[i] <= '0;
        else if (valid_r[i] && rank_r[i] < tref_c) rank_r[i] <= rank_r[i] + 1'b1;
      end else if (add_c) begin
        if (IW'(i) == slot_c) rank_r[i] <= '0;
        else if (valid_r[i]) rank_r[i] <= rank_r[i] + 1'b1;
      end
    end
    if (cmd.commit && cmd_r == lkv_pkg::CMD_PUT) begin
      key_r[slot_c] <= rkey_r;
      val_r[slot_c] <= rval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (add_c) begin
      valid_r[slot_c] <= 1'b1;
      count_r <= any_valid ? CW'(count_r + 1'b1) : CW'(1);
    end
  end

  assign found    = found_r;
  assign data_out = data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} <= (CW+1)'(ENTRIES)) else $error("count overflow");
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    CW'($countones(valid_r)) == count_r) else $error("count mismatch");
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $onehot0(hit_r)) else $error("duplicate key");
endmodule
`default_nettype wire

FILE: test/lru_key_value_cache_unit_tb.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit_tb: self-checking bench for the LRU key-value cache
// Sends get and put requests with random idling on both channels, predicts
// every result with a behavioral LRU store, and compares each result in order.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_key_value_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 64;

  typedef struct packed {
    logic        found;
    logic [31:0] data_out;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  lkv_req_if in_req ();
  lkv_rsp_if out_rsp ();

  lru_key_value_cache_unit #(.ENTRIES(Slots)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow of the cache contents, kept in step with each accepted request.
  logic [31:0] shadow_key [Slots];
  logic [31:0] shadow_val [Slots];
  bit          shadow_valid [Slots];
  int unsigned shadow_rank [Slots];
  int unsigned shadow_count;
  logic [6:0]  shadow_capacity;

  lookup_result_t pending_results[$];
  int  mismatches = 0;
  bit  idle_enable = 1'b1;
  longint cycles = 0;
  logic [31:0] recent_keys[$];

  // Move entry e to the most recent position.
  function automatic void promote(int e);
    int unsigned r;
    r = shadow_rank[e];
    for (int i = 0; i < Slots; i++)
      if (shadow_valid[i] && i != e && shadow_rank[i] < r) shadow_rank[i]++;
    shadow_rank[e] = 0;
  endfunction

  // Apply one request to the shadow store and return what the block must answer.
  function automatic lookup_result_t predict_lookup(lkv_pkg::cmd_t cmd, logic [31:0] key,
                                                     logic [31:0] val);
    lookup_result_t res;
    int hit, slot;
    int unsigned cap;
    hit = -1;
    slot = -1;
    for (int i = 0; i < Slots; i++)
      if (hit < 0 && shadow_valid[i] && shadow_key[i] == key) hit = i;
    if (cmd == lkv_pkg::CMD_GET) begin
      if (hit >= 0) begin
        promote(hit);
        res.found = 1'b1;
        res.data_out = shadow_val[hit];
      end else begin
        res.found = 1'b0;
        res.data_out = '1;
      end
      return res;
    end
    res.found = (hit >= 0);
    res.data_out = '0;
    if (hit >= 0) begin
      shadow_val[hit] = val;
      promote(hit);
      return res;
    end
    // A capacity of zero acts as one; above the slot count it is clamped.
    cap = (shadow_capacity == 0) ? 1 : shadow_capacity;
    if (cap > Slots) cap = Slots;
    if (shadow_count < cap)
      for (int i = 0; i < Slots; i++)
        if (slot < 0 && !shadow_valid[i]) slot = i;
    if (slot >= 0) begin
      for (int i = 0; i < Slots; i++)
        if (shadow_valid[i]) shadow_rank[i]++;
      shadow_valid[slot] = 1'b1;
      shadow_rank[slot] = 0;
      shadow_count++;
    end else begin
      // Evict the least recent entry; the count stays even if over capacity.
      for (int i = 0; i < Slots; i++)
        if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > shadow_rank[slot])) slot = i;
      promote(slot);
    end
    shadow_key[slot] = key;
    shadow_val[slot] = val;
    return res;
  endfunction

  function automatic bit idle_now();
    return idle_enable && ($urandom_range(99) < 26);
  endfunction

  // Sends one request, predicting its result at the edge where it is taken.
  // Valid stays high after acceptance so back-to-back requests need no gap;
  // it is dropped while idling and by drain_results.
  task automatic send_request(lkv_pkg::cmd_t cmd, logic [31:0] key, logic [31:0] val);
    while (idle_now()) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid   <= 1'b1;
    in_req.command <= cmd;
    in_req.key     <= key;
    in_req.value   <= val;
    do @(posedge clk); while (!in_req.ready);
    pending_results.push_back(predict_lookup(cmd, key, val));
    recent_keys.push_back(key);
    if (recent_keys.size() > 24) void'(recent_keys.pop_front());
  endtask

  // Result checker: the receiver stalls at random, compares on each accepted result.
  always @(posedge clk) begin
    lookup_result_t want;
    cycles++;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result found=%0b data=%h",
                                       out_rsp.found, out_rsp.data_out);
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.found !== want.found || out_rsp.data_out !== want.data_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected found=%0b data=%h, got found=%0b data=%h",
                     want.found, want.data_out, out_rsp.found, out_rsp.data_out);
        end
      end
    end
    out_rsp.ready <= !idle_now();
    if (cycles > 200000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic drain_results();
    in_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Capacity writes happen only with the block idle.
  task automatic write_capacity(logic [6:0] cap);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_capacity = cap;
  endtask

  function automatic logic [31:0] pick_key(int unsigned span);
    if (recent_keys.size() != 0 && $urandom_range(2) != 0)
      return recent_keys[$urandom_range(recent_keys.size() - 1)];
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(span);
  endfunction

  task automatic test_directed_edges();
    send_request(lkv_pkg::CMD_GET, 32'h0000_0000, '0);
    send_request(lkv_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(lkv_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(lkv_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lkv_pkg::CMD_GET, 32'h8000_0000, 32'h1234_5678);
    send_request(lkv_pkg::CMD_GET, 32'h7FFF_FFFF, '0);
    send_request(lkv_pkg::CMD_GET, 32'hFFFF_FFFF, '0);
    send_request(lkv_pkg::CMD_PUT, 32'h8000_0000, 32'h0000_0000);
    send_request(lkv_pkg::CMD_GET, 32'h8000_0000, '0);
    send_request(lkv_pkg::CMD_GET, 32'h0000_0001, '0);
  endtask

  // Capacity one: every new key evicts the least recent entry.
  task automatic test_capacity_one();
    write_capacity(7'd1);
    send_request(lkv_pkg::CMD_PUT, 32'd10, 32'd100);
    send_request(lkv_pkg::CMD_PUT, 32'd11, 32'd110);
    send_request(lkv_pkg::CMD_GET, 32'd10, '0);
    send_request(lkv_pkg::CMD_GET, 32'd11, '0);
  endtask

  // Zero acts as one, and the count left above it is not reduced.
  task automatic test_capacity_zero_and_over();
    write_capacity(7'd0);
    send_request(lkv_pkg::CMD_PUT, 32'd20, 32'd200);
    send_request(lkv_pkg::CMD_GET, 32'd20, '0);
    write_capacity(7'd127);
    for (int i = 0; i < 70; i++)
      send_request(lkv_pkg::CMD_PUT, $urandom_range(200), $urandom);
    write_capacity(7'd3);
    send_request(lkv_pkg::CMD_PUT, 32'hDEAD_BEEF, 32'd5);
    send_request(lkv_pkg::CMD_GET, 32'hDEAD_BEEF, '0);
  endtask

  task automatic test_random_phase(logic [6:0] cap, int count, int unsigned span);
    lkv_pkg::cmd_t cmd;
    write_capacity(cap);
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(1) != 0) ? lkv_pkg::CMD_PUT : lkv_pkg::CMD_GET;
      send_request(cmd, pick_key(span), $urandom);
    end
  endtask

  initial begin
    in_req.valid   = 1'b0;
    in_req.command = 1'b0;
    in_req.key     = '0;
    in_req.value   = '0;
    for (int i = 0; i < Slots; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
      shadow_key[i] = '0;
      shadow_val[i] = '0;
    end
    shadow_count = 0;
    shadow_capacity = 7'd64;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_capacity_one();
    test_capacity_zero_and_over();
    test_random_phase(7'd4, 150, 12);
    test_random_phase(7'd64, 150, 100);
    idle_enable = 1'b0;
    test_random_phase(7'd16, 120, 40);
    idle_enable = 1'b1;
    test_random_phase(7'd2, 120, 6);
    test_random_phase(7'd64, 60, 30);
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
